/* rtl/kde_pkg.sv */
// ----------------------------------------------------------------------------
// kde_pkg: shared types and constants of the knn distance engine
// Holds the beat payload structs, field widths, register indexes and codes.
// ----------------------------------------------------------------------------
package kde_pkg;

  // field widths
  localparam int VALUE_BITS = 16;
  localparam int LABEL_BITS = 8;
  localparam int IDX_BITS   = 24;
  localparam int ACC_BITS   = 48;
  localparam int DIMS_BITS  = 9;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 24;

  // saturation ceiling of the distance accumulator
  localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};

  // item kinds
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_TRAIN = 1'b1;

  // metric codes
  localparam logic MODE_MANHATTAN = 1'b0;
  localparam logic MODE_SQUARED   = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_METRIC_MODE  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_NUM_DIMS     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_INDEX_OFFSET = 2'd2;

  // input beat
  typedef struct packed {
    logic                         func;
    logic signed [VALUE_BITS-1:0] value;
    logic [LABEL_BITS-1:0]        train_label;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [IDX_BITS-1:0]   sample_index;
    logic [LABEL_BITS-1:0] sample_label;
    logic [ACC_BITS-1:0]   distance;
  } out_beat_t;

endpackage

/* rtl/kde_ram.sv */
// ----------------------------------------------------------------------------
// kde_ram: generic single-port-write, single-port-read ram
// One write and one registered read per cycle; read data holds without re.
// ----------------------------------------------------------------------------
module kde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // storage write
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/kde_metric.sv */
// ----------------------------------------------------------------------------
// kde_metric: one distance term and saturating accumulate
// Takes the stored and incoming dimension values, forms |a-b| or (a-b)^2
// and adds it to the running sum, clamping at the accumulator ceiling.
// ----------------------------------------------------------------------------
module kde_metric
  import kde_pkg::*;
(
  input  logic [VALUE_BITS-1:0]        test_val,
  input  logic signed [VALUE_BITS-1:0] sample_val,
  input  logic                         metric_mode,
  input  logic [ACC_BITS-1:0]          acc_in,
  output logic [ACC_BITS-1:0]          acc_out
);

  localparam int DIFF_W = VALUE_BITS + 1;
  localparam int SQ_W   = 2 * DIFF_W;

  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        mag;
  logic [SQ_W-1:0]          sq;
  logic [ACC_BITS:0]        term;
  logic [ACC_BITS:0]        sum;

  // difference and magnitude
  always_comb begin
    diff = DIFF_W'(signed'(test_val)) - DIFF_W'(sample_val);
    mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    sq   = SQ_W'(mag) * SQ_W'(mag);
  end

  // metric select and saturating add
  always_comb begin
    term = (metric_mode == MODE_SQUARED) ? (ACC_BITS+1)'(sq) : (ACC_BITS+1)'(mag);
    sum  = {1'b0, acc_in} + term;
    acc_out = (sum >= {1'b0, ACC_MAX}) ? ACC_MAX : sum[ACC_BITS-1:0];
  end

endmodule

/* rtl/knn_distance_engine.sv */
// ----------------------------------------------------------------------------
// knn_distance_engine: nearest-neighbour distance engine
// Streams dimension beats of a test sample into a vector store, then scores
// training samples against it with Manhattan or squared Euclidean distance.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one dimension per beat. func 0 loads the
//   test vector at the current position and restarts sample numbering;
//   func 1 scores a training dimension. Positions wrap after num_dims
//   beats (0 as 1, max MAX_DIMS). out_valid/out_stall/out_data deliver one
//   beat per completed training sample: index (index_offset + count), label
//   and saturated distance. cfg_we/cfg_index/cfg_wdata write metric_mode,
//   num_dims, index_offset; write them only while no beat is in flight.
// Timing:
//   one beat per cycle sustained while in_stall is low. An accepted beat
//   reads the vector store as it enters the scoring stage, is scored and
//   accumulated there; a final training beat loads the result register.
//   The store's registered read port sets the pipeline depth.
// Reset and stall:
//   reset clears counters, the accumulator, both valids and the registers to
//   their defaults; the test vector holds garbage until loaded.
//   While out_stall holds a waiting result, non-final beats still flow; only
//   a beat that would finish another sample raises in_stall.
// ----------------------------------------------------------------------------
module knn_distance_engine
  import kde_pkg::*;
#(
  parameter int MAX_DIMS = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_beat_t                 in_data,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_beat_t                out_data,
  // configuration
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  localparam int ADDR_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CMP_W  = (ADDR_W + 1 > DIMS_BITS + 1) ? ADDR_W + 1 : DIMS_BITS + 1;

  // configuration registers
  logic                  metric_mode_r;
  logic [DIMS_BITS-1:0]  num_dims_r;
  logic [IDX_BITS-1:0]   index_offset_r;

  // front-end state
  logic [ADDR_W-1:0]     dim_cnt_r, dim_cnt_nxt;
  logic [CMP_W-1:0]      eff_dims;
  logic                  last;
  logic                  in_fire;

  // scoring stage
  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_func_r;
  logic                  s1_last_r;
  logic signed [VALUE_BITS-1:0] s1_value_r;
  logic [LABEL_BITS-1:0] s1_label_r;
  logic                  s1_emit, s1_hold, s1_fire;
  logic [ACC_BITS-1:0]   acc_r, acc_nxt, acc_sum;
  logic [IDX_BITS-1:0]   sample_cnt_r, sample_cnt_nxt;
  logic [VALUE_BITS-1:0] test_rdata;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  out_beat_t             out_data_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_mode_r  <= MODE_MANHATTAN;
      num_dims_r     <= DIMS_BITS'(256);
      index_offset_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_METRIC_MODE:  metric_mode_r  <= cfg_wdata[0];
        REG_NUM_DIMS:     num_dims_r     <= cfg_wdata[DIMS_BITS-1:0];
        REG_INDEX_OFFSET: index_offset_r <= cfg_wdata[IDX_BITS-1:0];
        default: ;
      endcase
    end
  end

  // effective dimension count and end-of-sample detect
  always_comb begin
    eff_dims = CMP_W'(num_dims_r);
    if (eff_dims == '0) begin
      eff_dims = CMP_W'(1);
    end
    if (eff_dims > CMP_W'(MAX_DIMS)) begin
      eff_dims = CMP_W'(MAX_DIMS);
    end
    last = (CMP_W'(dim_cnt_r) + CMP_W'(1)) >= eff_dims;
  end

  // handshake
  assign s1_emit  = s1_valid_r && (s1_func_r == FUNC_TRAIN) && s1_last_r;
  assign s1_hold  = s1_emit && out_valid_r && out_stall;
  assign s1_fire  = s1_valid_r && !s1_hold;
  assign in_stall = s1_hold;
  assign in_fire  = in_valid && !in_stall;

  // position counter
  always_comb begin
    dim_cnt_nxt = dim_cnt_r;
    if (in_fire) begin
      dim_cnt_nxt = last ? '0 : dim_cnt_r + ADDR_W'(1);
    end
  end

  // test vector store
  kde_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_DIMS)
  ) u_test_ram (
    .clk   (clk),
    .we    (in_fire && (in_data.func == FUNC_LOAD)),
    .waddr (dim_cnt_r),
    .wdata (in_data.value),
    .re    (in_fire && (in_data.func == FUNC_TRAIN)),
    .raddr (dim_cnt_r),
    .rdata (test_rdata)
  );

  // distance term and accumulate
  kde_metric u_metric (
    .test_val    (test_rdata),
    .sample_val  (s1_value_r),
    .metric_mode (metric_mode_r),
    .acc_in      (acc_r),
    .acc_out     (acc_sum)
  );

  // scoring stage next state
  always_comb begin
    s1_valid_nxt   = s1_valid_r;
    acc_nxt        = acc_r;
    sample_cnt_nxt = sample_cnt_r;
    if (s1_fire) begin
      s1_valid_nxt = 1'b0;
      if (s1_func_r == FUNC_LOAD) begin
        acc_nxt        = '0;
        sample_cnt_nxt = '0;
      end else if (s1_last_r) begin
        acc_nxt        = '0;
        sample_cnt_nxt = sample_cnt_r + IDX_BITS'(1);
      end else begin
        acc_nxt = acc_sum;
      end
    end
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end
  end

  // result register next state
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (s1_fire && s1_emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_cnt_r    <= '0;
      s1_valid_r   <= 1'b0;
      acc_r        <= '0;
      sample_cnt_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      dim_cnt_r    <= dim_cnt_nxt;
      s1_valid_r   <= s1_valid_nxt;
      acc_r        <= acc_nxt;
      sample_cnt_r <= sample_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // scoring stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func_r  <= in_data.func;
      s1_value_r <= in_data.value;
      s1_label_r <= in_data.train_label;
      s1_last_r  <= last;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (s1_fire && s1_emit) begin
      out_data_r.sample_index <= index_offset_r + sample_cnt_r;
      out_data_r.sample_label <= s1_label_r;
      out_data_r.distance     <= acc_sum;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for knn_distance_engine
// Fills the test vector, runs a directed pass over the counting, wrap and
// metric corner cases, then random phases of load and training samples with
// random sender bursts and receiver stalls. Every result beat is checked
// field by field against an in-bench distance predictor.
// ----------------------------------------------------------------------------
module tb;
  import kde_pkg::*;

  localparam int DIM_CAP     = 256;
  localparam int ITEM_TARGET = 1450;
  localparam int IDLE_LIMIT  = 3000;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  knn_distance_engine DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // beats waiting to be sent and distances waiting to come back
  in_beat_t  beats_todo [$];
  out_beat_t scores_due [$];
  int unsigned n_queued = 0;
  int unsigned n_taken = 0;
  int unsigned errors = 0;

  // shadow registers
  logic                 metric_sh = MODE_MANHATTAN;
  logic [DIMS_BITS-1:0] dims_sh = 9'd256;
  logic [IDX_BITS-1:0]  offset_sh = '0;

  // predictor state
  logic signed [VALUE_BITS-1:0] probe_vec [DIM_CAP];
  int unsigned                  probe_pos = 0;
  logic [ACC_BITS-1:0]          dist_acc = '0;
  logic [IDX_BITS-1:0]          sample_cnt = '0;

  // advance the predictor by one accepted beat
  function automatic void score_beat(input in_beat_t b);
    int unsigned n, pos;
    logic last;
    logic signed [VALUE_BITS:0] diff;
    logic [VALUE_BITS:0] mag;
    logic [ACC_BITS-1:0] term;
    out_beat_t r;
    n = (dims_sh == '0) ? 1 : ((32'(dims_sh) > DIM_CAP) ? DIM_CAP : 32'(dims_sh));
    pos = probe_pos % DIM_CAP;
    last = (pos + 1) >= n;
    if (b.func == FUNC_LOAD) begin
      probe_vec[pos] = b.value;
      dist_acc = '0;
      sample_cnt = '0;
      probe_pos = last ? 0 : pos + 1;
      return;
    end
    diff = $signed({probe_vec[pos][VALUE_BITS-1], probe_vec[pos]})
         - $signed({b.value[VALUE_BITS-1], b.value});
    mag = diff[VALUE_BITS] ? -diff : diff;
    term = (metric_sh == MODE_SQUARED) ? ACC_BITS'(mag) * ACC_BITS'(mag) : ACC_BITS'(mag);
    if (term >= ACC_MAX - dist_acc) dist_acc = ACC_MAX;
    else dist_acc = dist_acc + term;
    if (!last) begin
      probe_pos = pos + 1;
      return;
    end
    r.sample_index = offset_sh + sample_cnt;
    r.sample_label = b.train_label;
    r.distance = dist_acc;
    scores_due.push_back(r);
    dist_acc = '0;
    probe_pos = 0;
    sample_cnt = sample_cnt + IDX_BITS'(1);
  endfunction

  // sender: bursts of random length with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (beats_todo.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= beats_todo.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern switching between free, sparse and heavy
  int unsigned pat_mode = 0;
  int unsigned pat_left = 0;

  always @(posedge clk) begin
    if (pat_left == 0) begin
      pat_mode = $urandom_range(0, 2);
      pat_left = $urandom_range(10, 80);
    end else begin
      pat_left--;
    end
    case (pat_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // monitor: predict on input beats, check result beats
  out_beat_t want;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        score_beat(in_data);
        n_taken++;
      end
      if (out_valid && !out_stall) begin
        if (scores_due.size() == 0) begin
          $error("unexpected result beat: sample_index %0d", out_data.sample_index);
          errors++;
        end else begin
          want = scores_due.pop_front();
          if (out_data.sample_index !== want.sample_index) begin
            $error("sample_index: expected %0d, got %0d",
                   want.sample_index, out_data.sample_index);
            errors++;
          end
          if (out_data.sample_label !== want.sample_label) begin
            $error("sample_label: expected %0d, got %0d",
                   want.sample_label, out_data.sample_label);
            errors++;
          end
          if (out_data.distance !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, out_data.distance);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no beat moving
  int unsigned idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // value with extra weight on the extremes and zero
  function automatic logic signed [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return '0;
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  task automatic queue_beat(input logic f, input logic signed [VALUE_BITS-1:0] v,
                            input logic [LABEL_BITS-1:0] lab);
    in_beat_t b;
    b.func = f;
    b.value = v;
    b.train_label = lab;
    beats_todo.push_back(b);
    n_queued++;
  endtask

  // one sample of n beats, with an occasional stray beat kind or label
  task automatic queue_sample(input logic f, input int unsigned n,
                              input logic [LABEL_BITS-1:0] lab);
    repeat (n) begin
      if ($urandom_range(0, 15) == 0) queue_beat(~f, pick_value(), LABEL_BITS'($urandom));
      else queue_beat(f, pick_value(), lab);
    end
  endtask

  // wait for every beat to be taken and every result back, then let the pipe empty
  task automatic wait_idle();
    while (n_taken != n_queued || scores_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_METRIC_MODE:  metric_sh = data[0];
      REG_NUM_DIMS:     dims_sh = data[DIMS_BITS-1:0];
      REG_INDEX_OFFSET: offset_sh = data[IDX_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned dims, nsamp;
    logic [CFG_DATA_BITS-1:0] wdata;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the whole test vector at the reset dimension count
    queue_beat(FUNC_LOAD, VAL_MIN, '0);
    queue_beat(FUNC_LOAD, VAL_MAX, '1);
    for (int i = 2; i < DIM_CAP; i++) queue_beat(FUNC_LOAD, pick_value(), LABEL_BITS'($urandom));
    wait_idle();

    // manhattan extremes, indexes up to the top of the range
    write_reg(REG_UNUSED, '1);
    write_reg(REG_METRIC_MODE, MODE_MANHATTAN);
    write_reg(REG_NUM_DIMS, 2);
    write_reg(REG_INDEX_OFFSET, 24'hFFFFFE);
    queue_beat(FUNC_LOAD, VAL_MIN, 8'h00);
    queue_beat(FUNC_LOAD, VAL_MAX, 8'hFF);
    queue_beat(FUNC_TRAIN, VAL_MAX, 8'h00);
    queue_beat(FUNC_TRAIN, VAL_MIN, 8'h00);
    queue_beat(FUNC_TRAIN, VAL_MIN, 8'hA5);
    queue_beat(FUNC_TRAIN, VAL_MAX, 8'hFF);
    wait_idle();

    // squared extremes, index wrapping past the top of the range
    write_reg(REG_METRIC_MODE, MODE_SQUARED);
    queue_beat(FUNC_TRAIN, VAL_MAX, 8'h00);
    queue_beat(FUNC_TRAIN, VAL_MIN, 8'h5A);
    wait_idle();

    // zero dimension count behaves as one
    write_reg(REG_NUM_DIMS, 0);
    write_reg(REG_INDEX_OFFSET, 0);
    queue_beat(FUNC_TRAIN, 16'sd0, 8'h01);
    queue_beat(FUNC_LOAD, 16'sd100, 8'h00);
    queue_beat(FUNC_TRAIN, -16'sd1, 8'h02);
    wait_idle();

    // count lowered in the middle of a training sample
    write_reg(REG_NUM_DIMS, 5);
    queue_beat(FUNC_TRAIN, 16'sd1, 8'h03);
    queue_beat(FUNC_TRAIN, 16'sd2, 8'h03);
    queue_beat(FUNC_TRAIN, 16'sd3, 8'h03);
    wait_idle();
    write_reg(REG_NUM_DIMS, 2);
    queue_beat(FUNC_TRAIN, 16'sd4, 8'h03);
    wait_idle();

    // count lowered in the middle of a load
    write_reg(REG_NUM_DIMS, 5);
    queue_sample(FUNC_LOAD, 3, 8'h00);
    wait_idle();
    write_reg(REG_NUM_DIMS, 2);
    queue_beat(FUNC_LOAD, pick_value(), 8'h00);
    wait_idle();

    // metric switched mid-sample
    write_reg(REG_NUM_DIMS, 4);
    write_reg(REG_METRIC_MODE, MODE_MANHATTAN);
    queue_beat(FUNC_TRAIN, VAL_MAX, 8'h10);
    queue_beat(FUNC_TRAIN, -16'sd300, 8'h10);
    wait_idle();
    write_reg(REG_METRIC_MODE, MODE_SQUARED);
    queue_beat(FUNC_TRAIN, 16'sd77, 8'h10);
    queue_beat(FUNC_TRAIN, VAL_MIN, 8'h11);
    wait_idle();

    // load and training beats mixed on the shared position
    write_reg(REG_NUM_DIMS, 3);
    queue_beat(FUNC_LOAD, 16'sd5, 8'h00);
    queue_beat(FUNC_TRAIN, 16'sd9, 8'h20);
    queue_beat(FUNC_LOAD, -16'sd7, 8'h00);
    queue_sample(FUNC_TRAIN, 3, 8'h21);

    // random phases, each one starting from an idle block
    while (n_queued < ITEM_TARGET) begin
      wait_idle();
      case ($urandom_range(0, 39))
        0: dims = DIM_CAP;
        1: dims = $urandom_range(DIM_CAP + 1, 511);
        2: dims = 0;
        3, 4: dims = 1;
        default: dims = $urandom_range(2, 8);
      endcase
      wdata = CFG_DATA_BITS'(dims);
      if ($urandom_range(0, 3) == 0) begin
        wdata[CFG_DATA_BITS-1:DIMS_BITS] = (CFG_DATA_BITS-DIMS_BITS)'($urandom);
      end
      write_reg(REG_NUM_DIMS, wdata);
      wdata = CFG_DATA_BITS'($urandom_range(0, 1));
      if ($urandom_range(0, 3) == 0) wdata[CFG_DATA_BITS-1:1] = (CFG_DATA_BITS-1)'($urandom);
      write_reg(REG_METRIC_MODE, wdata);
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: wdata = '0;
          1: wdata = '1;
          2: wdata = '1 - CFG_DATA_BITS'($urandom_range(0, 8));
          default: wdata = CFG_DATA_BITS'($urandom);
        endcase
        write_reg(REG_INDEX_OFFSET, wdata);
      end
      // sizes used only to shape the sequence length
      if (dims == 0) dims = 1;
      if (dims > DIM_CAP) dims = DIM_CAP;
      if (dims <= 16 && $urandom_range(0, 1) == 0) begin
        queue_sample(FUNC_LOAD, dims, LABEL_BITS'($urandom));
      end
      nsamp = (dims > 16) ? 1 : $urandom_range(2, 8);
      repeat (nsamp) queue_sample(FUNC_TRAIN, dims, LABEL_BITS'($urandom));
      repeat ($urandom_range(0, 3)) queue_beat(1'($urandom), pick_value(), LABEL_BITS'($urandom));
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
